@@ rtl/lup_decomposition_unit_defines.svh @@
// Assertion macros for the LU decomposition unit.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef LUP_DECOMPOSITION_UNIT_DEFINES_SVH
`define LUP_DECOMPOSITION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LUP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LUP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lup_pkg.sv @@
// Shared types and constants of the LU decomposition unit.
// No dependencies; imported by every RTL module and the testbench.
`default_nettype none

package lup_pkg;

  // Widest store address and row index over the supported matrix sizes.
  localparam int ADDR_MAX_W = 6;
  localparam int IDX_MAX_W  = 3;

  // Configuration register indexes.
  localparam logic CFG_IDX_MATRIX_SIZE = 1'b0;
  localparam logic CFG_IDX_THRESHOLD   = 1'b1;

  localparam logic signed [31:0] FIX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FIX_MIN = 32'sh8000_0000;

  // Source of the data written into the matrix store.
  typedef enum logic [2:0] {
    WSEL_IN,
    WSEL_RD,
    WSEL_TMP,
    WSEL_DIV,
    WSEL_UPD
  } wsel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
    wsel_t                 wsel;
    logic                  tmp_ld;
    logic                  pv_ld;
    logic                  div_start;
    logic                  l_ld;
    logic                  u_ld;
    logic                  mul;
    logic                  trunc_ld;
    logic                  best_clr;
    logic                  best_upd;
    logic                  perm_init;
    logic [IDX_MAX_W-1:0]  perm_idx;
    logic                  ptmp_ld;
    logic                  pq_ld;
    logic                  perm_wr;
    logic                  perm_sel_pq;
    logic                  out_ld;
    logic                  out_sing;
    logic                  out_last;
    logic [IDX_MAX_W-1:0]  out_row;
    logic [IDX_MAX_W-1:0]  out_col;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mag_gt;
    logic below;
    logic div_done;
  } status_t;

  // Saturate a wide signed difference to 32 bits.
  function automatic logic signed [31:0] sat32(logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'(FIX_MAX)) begin
      r = FIX_MAX;
    end else if (v < 65'(FIX_MIN)) begin
      r = FIX_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lup_div.sv @@
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits. Depends on lup_pkg.
`default_nettype none

module lup_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import lup_pkg::*;

  localparam int DW   = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(DW + 1);

  logic            busy_r;
  logic            fin_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   dvd_r;
  logic [31:0]     rem_r;
  logic [31:0]     dmag_r;
  logic            neg_r;
  logic signed [31:0] quo_r;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  // One quotient bit per cycle by restoring division on magnitudes.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dmag_r};
    ge      = (rem_sh >= {1'b0, dmag_r});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNTW'(DW);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Operand, remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      if (den == 32'sd0) begin
        if (num > 32'sd0) begin
          quo_r <= FIX_MAX;
        end else if (num < 32'sd0) begin
          quo_r <= FIX_MIN;
        end else begin
          quo_r <= 32'sd0;
        end
      end
      dvd_r  <= {mag32(num), FRAC_BITS'(0)};
      rem_r  <= '0;
      dmag_r <= mag32(den);
      neg_r  <= num[31] ^ den[31];
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd_r <= {dvd_r[DW-2:0], ge};
    end else if (fin_r) begin
      // Apply the sign and saturate the quotient magnitude.
      if (neg_r) begin
        if (dvd_r > DW'(33'h0_8000_0000)) begin
          quo_r <= FIX_MIN;
        end else begin
          quo_r <= ~dvd_r[31:0] + 32'd1;
        end
      end else begin
        if (dvd_r > DW'(33'h0_7FFF_FFFF)) begin
          quo_r <= FIX_MAX;
        end else begin
          quo_r <= dvd_r[31:0];
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

@@ rtl/lup_dp.sv @@
// Datapath of the LU decomposition unit: matrix store, permutation, pivot
// search, divider, multiply-subtract and result registers. Depends on lup_pkg, lup_div.
`default_nettype none

module lup_dp #(
  parameter int MATRIX_DIM = 4,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lup_pkg::cmd_t      cmd,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic [30:0]        threshold,
  output lup_pkg::status_t        status,
  output logic                    out_valid,
  output logic signed [31:0]      out_lu_value,
  output logic [1:0]              out_row_index,
  output logic [1:0]              out_col_index,
  output logic [1:0]              out_source_row,
  output logic                    out_singular,
  output logic                    out_last
);
  import lup_pkg::*;

  localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MATRIX_DIM);
  localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic signed [31:0] tmp_r;
  logic signed [31:0] piv_val_r;
  logic signed [31:0] l_r;
  logic signed [31:0] u_r;
  logic signed [31:0] a_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] trunc_r;
  logic [31:0]        best_r;
  logic [IW-1:0]      perm_r [MATRIX_DIM];
  logic [IW-1:0]      ptmp_r;
  logic [IW-1:0]      pq_r;

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_row_r;
  logic [1:0]         out_col_r;
  logic [1:0]         out_src_r;
  logic               out_sing_r;
  logic               out_last_r;

  logic signed [31:0] wdata;
  logic signed [31:0] div_quo;
  logic               div_done;
  logic [31:0]        mag_cur;
  logic signed [63:0] trunc_nxt;
  logic [IW-1:0]      perm_rd;

  // Divider for the L multipliers.
  lup_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (rdata_r),
    .den   (piv_val_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Store write data selection.
  always_comb begin
    case (cmd.wsel)
      WSEL_IN:  wdata = in_element_value;
      WSEL_RD:  wdata = rdata_r;
      WSEL_TMP: wdata = tmp_r;
      WSEL_DIV: wdata = div_quo;
      WSEL_UPD: wdata = sat32(65'(a_r) - 65'(trunc_r));
      default:  wdata = rdata_r;
    endcase
  end

  // Product scaled down by 2^FRAC_BITS, truncated toward zero.
  always_comb begin
    if (prod_r[63]) begin
      trunc_nxt = (prod_r + BIAS) >>> FRAC_BITS;
    end else begin
      trunc_nxt = prod_r >>> FRAC_BITS;
    end
  end

  assign mag_cur = mag32(rdata_r);
  assign perm_rd = perm_r[cmd.perm_idx[IW-1:0]];

  // Matrix store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  // Working registers of the elimination.
  always_ff @(posedge clk) begin
    if (cmd.tmp_ld) begin
      tmp_r <= rdata_r;
    end
    if (cmd.pv_ld) begin
      piv_val_r <= rdata_r;
    end
    if (cmd.l_ld) begin
      l_r <= div_quo;
    end
    if (cmd.u_ld) begin
      u_r <= rdata_r;
    end
    if (cmd.mul) begin
      a_r    <= rdata_r;
      prod_r <= l_r * u_r;
    end
    if (cmd.trunc_ld) begin
      trunc_r <= trunc_nxt;
    end
    if (cmd.best_clr) begin
      best_r <= '0;
    end else if (cmd.best_upd && status.mag_gt) begin
      best_r <= mag_cur;
    end
  end

  // Row permutation, swapped one entry per cycle.
  always_ff @(posedge clk) begin
    if (cmd.perm_init) begin
      for (int p = 0; p < MATRIX_DIM; p++) begin
        perm_r[p] <= IW'(p);
      end
    end else if (cmd.perm_wr) begin
      perm_r[cmd.perm_idx[IW-1:0]] <= cmd.perm_sel_pq ? pq_r : ptmp_r;
    end
    if (cmd.ptmp_ld) begin
      ptmp_r <= perm_rd;
    end
    if (cmd.pq_ld) begin
      pq_r <= perm_rd;
    end
  end

  // Result registers; the strobe is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_row_r  <= 2'(cmd.out_row);
      out_col_r  <= 2'(cmd.out_col);
      out_sing_r <= cmd.out_sing;
      out_last_r <= cmd.out_last;
      if (cmd.out_sing) begin
        out_value_r <= 32'sd0;
        out_src_r   <= 2'd0;
      end else begin
        out_value_r <= rdata_r;
        out_src_r   <= 2'(perm_rd);
      end
    end
  end

  always_comb begin
    status.mag_gt   = (mag_cur > best_r);
    status.below    = (best_r < {1'b0, threshold});
    status.div_done = div_done;
  end

  assign out_valid      = out_valid_r;
  assign out_lu_value   = out_value_r;
  assign out_row_index  = out_row_r;
  assign out_col_index  = out_col_r;
  assign out_source_row = out_src_r;
  assign out_singular   = out_sing_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

@@ rtl/lup_ctrl.sv @@
// Sequencer of the LU decomposition unit: loading, pivot search, row swap,
// elimination and result readout. Depends on lup_pkg.
`default_nettype none

module lup_ctrl #(
  parameter int MATRIX_DIM = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [$clog2(MATRIX_DIM+1)-1:0]  dim,
  input  wire lup_pkg::status_t                 status,
  output logic                                  busy,
  output lup_pkg::cmd_t                         cmd
);
  import lup_pkg::*;

  localparam int NW = $clog2(MATRIX_DIM + 1);
  localparam int IW = $clog2(MATRIX_DIM);
  localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);
  localparam int CW = $clog2(MATRIX_DIM * MATRIX_DIM + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PV_START, ST_PV_RD, ST_PV_CMP, ST_PV_CHK,
    ST_PM0, ST_PM1, ST_PM2, ST_PM3,
    ST_SW0, ST_SW1, ST_SW2, ST_SW3,
    ST_EL_PV, ST_EL_PV2, ST_EL_RD, ST_EL_DIV, ST_EL_WAIT,
    ST_K0, ST_K1, ST_K2, ST_K3, ST_K4,
    ST_NEXT, ST_OUT_RD, ST_OUT_LD, ST_SING
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] piv_r, piv_nxt;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic          busy_r;

  logic [CW-1:0] total;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_inc;
  logic [IW-1:0] nm1;

  // Flat store address of an element, as r*n+c.
  function automatic logic [ADDR_MAX_W-1:0] addr_of(logic [IW-1:0] row,
                                                    logic [IW-1:0] col,
                                                    logic [NW-1:0] n);
    logic [AW-1:0] a;
    a = AW'(AW'(row) * AW'(n) + AW'(col));
    return ADDR_MAX_W'(a);
  endfunction

  assign total   = CW'(dim) * CW'(dim);
  assign pos     = (load_cnt_r >= total) ? '0 : load_cnt_r;
  assign pos_inc = pos + CW'(1);
  assign nm1     = IW'(dim - NW'(1));

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    piv_nxt      = piv_r;
    load_cnt_nxt = load_cnt_r;
    cmd          = '0;
    cmd.wsel     = WSEL_RD;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = ADDR_MAX_W'(pos[AW-1:0]);
          cmd.wsel    = WSEL_IN;
          if (pos_inc == total) begin
            load_cnt_nxt  = '0;
            cmd.perm_init = 1'b1;
            i_nxt         = '0;
            state_nxt     = ST_PV_START;
          end else begin
            load_cnt_nxt = pos_inc;
          end
        end
      end

      // Pivot search down column i.
      ST_PV_START: begin
        cmd.best_clr = 1'b1;
        k_nxt        = i_r;
        piv_nxt      = i_r;
        state_nxt    = ST_PV_RD;
      end
      ST_PV_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(k_r, i_r, dim);
        state_nxt   = ST_PV_CMP;
      end
      ST_PV_CMP: begin
        cmd.best_upd = 1'b1;
        if (status.mag_gt) begin
          piv_nxt = k_r;
        end
        if (k_r == nm1) begin
          state_nxt = ST_PV_CHK;
        end else begin
          k_nxt     = k_r + IW'(1);
          state_nxt = ST_PV_RD;
        end
      end
      ST_PV_CHK: begin
        if (status.below) begin
          state_nxt = ST_SING;
        end else if (piv_r != i_r) begin
          state_nxt = ST_PM0;
        end else begin
          state_nxt = ST_EL_PV;
        end
      end

      // Swap permutation entries i and piv.
      ST_PM0: begin
        cmd.perm_idx = IDX_MAX_W'(i_r);
        cmd.ptmp_ld  = 1'b1;
        state_nxt    = ST_PM1;
      end
      ST_PM1: begin
        cmd.perm_idx = IDX_MAX_W'(piv_r);
        cmd.pq_ld    = 1'b1;
        state_nxt    = ST_PM2;
      end
      ST_PM2: begin
        cmd.perm_idx    = IDX_MAX_W'(i_r);
        cmd.perm_wr     = 1'b1;
        cmd.perm_sel_pq = 1'b1;
        state_nxt       = ST_PM3;
      end
      ST_PM3: begin
        cmd.perm_idx = IDX_MAX_W'(piv_r);
        cmd.perm_wr  = 1'b1;
        j_nxt        = '0;
        state_nxt    = ST_SW0;
      end

      // Swap rows i and piv, one element per pass through ST_SW0 to ST_SW3.
      ST_SW0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(i_r, j_r, dim);
        state_nxt   = ST_SW1;
      end
      ST_SW1: begin
        cmd.tmp_ld  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(piv_r, j_r, dim);
        state_nxt   = ST_SW2;
      end
      ST_SW2: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_of(i_r, j_r, dim);
        cmd.wsel    = WSEL_RD;
        state_nxt   = ST_SW3;
      end
      ST_SW3: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_of(piv_r, j_r, dim);
        cmd.wsel    = WSEL_TMP;
        if (j_r == nm1) begin
          state_nxt = ST_EL_PV;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = ST_SW0;
        end
      end

      // Fetch the pivot value.
      ST_EL_PV: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(i_r, i_r, dim);
        state_nxt   = ST_EL_PV2;
      end
      ST_EL_PV2: begin
        cmd.pv_ld = 1'b1;
        if (i_r == nm1) begin
          state_nxt = ST_NEXT;
        end else begin
          j_nxt     = i_r + IW'(1);
          state_nxt = ST_EL_RD;
        end
      end

      // Multiplier for row j.
      ST_EL_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(j_r, i_r, dim);
        state_nxt   = ST_EL_DIV;
      end
      ST_EL_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_EL_WAIT;
      end
      ST_EL_WAIT: begin
        if (status.div_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = addr_of(j_r, i_r, dim);
          cmd.wsel    = WSEL_DIV;
          cmd.l_ld    = 1'b1;
          k_nxt       = i_r + IW'(1);
          state_nxt   = ST_K0;
        end
      end

      // Update element (j, k) of the trailing block.
      ST_K0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(i_r, k_r, dim);
        state_nxt   = ST_K1;
      end
      ST_K1: begin
        cmd.u_ld    = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = addr_of(j_r, k_r, dim);
        state_nxt   = ST_K2;
      end
      ST_K2: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_K3;
      end
      ST_K3: begin
        cmd.trunc_ld = 1'b1;
        state_nxt    = ST_K4;
      end
      ST_K4: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = addr_of(j_r, k_r, dim);
        cmd.wsel    = WSEL_UPD;
        if (k_r == nm1) begin
          if (j_r == nm1) begin
            state_nxt = ST_NEXT;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = ST_EL_RD;
          end
        end else begin
          k_nxt     = k_r + IW'(1);
          state_nxt = ST_K0;
        end
      end

      ST_NEXT: begin
        if (i_r == nm1) begin
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_OUT_RD;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_PV_START;
        end
      end

      // Read out the combined matrix, row j, column k.
      ST_OUT_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_addr  = addr_of(j_r, k_r, dim);
        cmd.perm_idx = IDX_MAX_W'(j_r);
        state_nxt    = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd.perm_idx = IDX_MAX_W'(j_r);
        cmd.out_ld   = 1'b1;
        cmd.out_row  = IDX_MAX_W'(j_r);
        cmd.out_col  = IDX_MAX_W'(k_r);
        cmd.out_last = (j_r == nm1) && (k_r == nm1);
        if (k_r == nm1) begin
          k_nxt = '0;
          if (j_r == nm1) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = ST_OUT_RD;
          end
        end else begin
          k_nxt     = k_r + IW'(1);
          state_nxt = ST_OUT_RD;
        end
      end

      ST_SING: begin
        cmd.out_ld   = 1'b1;
        cmd.out_sing = 1'b1;
        cmd.out_last = 1'b1;
        cmd.out_row  = IDX_MAX_W'(i_r);
        cmd.out_col  = IDX_MAX_W'(i_r);
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and the registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      busy_r     <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      piv_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      busy_r     <= (state_nxt != ST_IDLE);
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      piv_r      <= piv_nxt;
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

@@ rtl/lup_decomposition_unit.sv @@
// LU decomposition with partial pivoting of an n x n Q16.16 matrix.
// Elements load one per cycle while busy is low; after the last element the
// unit stays busy through the factoring and readout, set mostly by the
// bit-serial divider (one run per multiplier) and the registered store read
// (each readout result is read, then loaded). Results leave one at a time.
// Synchronous active-low reset restores n=4, threshold 1.
`default_nettype none

module lup_decomposition_unit #(
  parameter int MATRIX_DIM = 4,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [30:0]        cfg_wdata,
  output logic                    out_valid,
  output logic signed [31:0]      out_lu_value,
  output logic [1:0]              out_row_index,
  output logic [1:0]              out_col_index,
  output logic [1:0]              out_source_row,
  output logic                    out_singular,
  output logic                    out_last
);
  import lup_pkg::*;
  `include "lup_decomposition_unit_defines.svh"

  localparam int NW = $clog2(MATRIX_DIM + 1);

  logic [2:0]    size_r;
  logic [30:0]   thr_r;
  logic [NW-1:0] dim;
  cmd_t          cmd;
  status_t       status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 3'd4;
      thr_r  <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MATRIX_SIZE: size_r <= cfg_wdata[2:0];
        CFG_IDX_THRESHOLD:   thr_r  <= cfg_wdata;
        default:             size_r <= size_r;
      endcase
    end
  end

  // Dimension in use: zero acts as one, larger sizes clamp to the built size.
  always_comb begin
    if (size_r == 3'd0) begin
      dim = NW'(1);
    end else if (32'(size_r) > MATRIX_DIM) begin
      dim = NW'(MATRIX_DIM);
    end else begin
      dim = NW'(size_r);
    end
  end

  lup_ctrl #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .dim    (dim),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  lup_dp #(
    .MATRIX_DIM(MATRIX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_element_value (in_element_value),
    .threshold        (thr_r),
    .status           (status),
    .out_valid        (out_valid),
    .out_lu_value     (out_lu_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_source_row   (out_source_row),
    .out_singular     (out_singular),
    .out_last         (out_last)
  );

  // Checks on the sequencing.
  `LUP_ASSERT_NXT(a_out_follows_load, cmd.out_ld, out_valid, "result load without strobe")
  `LUP_ASSERT_IMP(a_mid_result_busy, out_valid && !out_last, busy, "idle before last result")
  `LUP_ASSERT_IMP(a_div_done_busy, status.div_done, busy, "divider done while idle")

endmodule

`default_nettype wire

@@ verif/lup_decomposition_unit_tb.sv @@
// Self-checking testbench for the LU decomposition unit with partial pivoting.
// Depends on lup_pkg and lup_decomposition_unit; predicts every LU entry in
// fixed point and compares each result transaction field by field.
`timescale 1ns / 100ps

module lup_decomposition_unit_tb;
  import lup_pkg::*;

  localparam int  CYCLE_LIMIT = 600000;
  localparam int  SETTLE      = 40;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // One combined L/U entry as it leaves the unit.
  typedef struct packed {
    logic signed [31:0] lu_value;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic [1:0]         source_row;
    logic               singular;
    logic               last;
  } lu_entry_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_element_value;
  logic               cfg_we;
  logic               cfg_index;
  logic [30:0]        cfg_wdata;
  logic               out_valid;
  logic signed [31:0] out_lu_value;
  logic [1:0]         out_row_index;
  logic [1:0]         out_col_index;
  logic [1:0]         out_source_row;
  logic               out_singular;
  logic               out_last;

  // Shadow copy of the unit's configuration and matrix state.
  logic [2:0]         size_reg;
  logic [30:0]        thresh_reg;
  logic signed [31:0] mat[16];
  logic [1:0]         row_src[4];
  int                 load_pos;

  lu_entry_t          pending_entries[$];
  int                 mismatches;
  int                 cycle_count;
  int                 elements_sent;
  bit                 steady_send;

  lup_decomposition_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_element_value (in_element_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_lu_value     (out_lu_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_source_row   (out_source_row),
    .out_singular     (out_singular),
    .out_last         (out_last)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Saturate a wide signed value to the Q16.16 range.
  function automatic logic signed [31:0] clamp_q(longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = FIX_MAX;
    end else if (v < -64'sd2147483648) begin
      r = FIX_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Multiplier: numerator scaled up and divided, truncated toward zero.
  function automatic logic signed [31:0] q_divide(logic signed [31:0] num,
                                                   logic signed [31:0] den);
    longint scaled;
    logic signed [31:0] r;
    scaled = longint'(num) * 64'sd65536;
    if (den == 0) begin
      r = (num > 0) ? FIX_MAX : ((num < 0) ? FIX_MIN : 32'sd0);
    end else begin
      r = clamp_q(scaled / longint'(den));
    end
    return r;
  endfunction

  function automatic longint abs_q(logic signed [31:0] v);
    longint w;
    w = longint'(v);
    return (w < 0) ? -w : w;
  endfunction

  // In-place decomposition of the shadow matrix; returns the failing column,
  // or n when every pivot was large enough.
  function automatic int factor_matrix(int n);
    int i, j, k, piv;
    longint best, m, prod;
    logic signed [31:0] l, x;
    logic [1:0] t;
    for (i = 0; i < n; i++) row_src[i] = i[1:0];
    for (i = 0; i < n; i++) begin
      best = 0;
      piv = i;
      for (k = i; k < n; k++) begin
        m = abs_q(mat[k*n+i]);
        if (m > best) begin
          best = m;
          piv = k;
        end
      end
      if (best < longint'(thresh_reg)) return i;
      if (piv != i) begin
        t = row_src[i];
        row_src[i] = row_src[piv];
        row_src[piv] = t;
        for (j = 0; j < n; j++) begin
          x = mat[i*n+j];
          mat[i*n+j] = mat[piv*n+j];
          mat[piv*n+j] = x;
        end
      end
      for (j = i + 1; j < n; j++) begin
        l = q_divide(mat[j*n+i], mat[i*n+i]);
        mat[j*n+i] = l;
        for (k = i + 1; k < n; k++) begin
          prod = longint'(l) * longint'(mat[i*n+k]);
          mat[j*n+k] = clamp_q(longint'(mat[j*n+k]) - prod / 64'sd65536);
        end
      end
    end
    return n;
  endfunction

  // Load one element into the shadow store; a full matrix queues its entries.
  task automatic predict_element(input logic signed [31:0] v);
    int n, total, pos, fail, r, c;
    lu_entry_t e;
    n = (size_reg == 0) ? 1 : ((size_reg > 4) ? 4 : int'(size_reg));
    total = n * n;
    pos = (load_pos >= total) ? 0 : load_pos;
    mat[pos] = v;
    pos++;
    if (pos < total) begin
      load_pos = pos;
    end else begin
      load_pos = 0;
      fail = factor_matrix(n);
      if (fail < n) begin
        e = '{lu_value: 32'sd0, row_index: fail[1:0], col_index: fail[1:0],
              source_row: 2'd0, singular: 1'b1, last: 1'b1};
        pending_entries.push_back(e);
      end else begin
        for (r = 0; r < n; r++) begin
          for (c = 0; c < n; c++) begin
            e = '{lu_value: mat[r*n+c], row_index: r[1:0], col_index: c[1:0],
                  source_row: row_src[r], singular: 1'b0,
                  last: (r*n + c + 1 == total)};
            pending_entries.push_back(e);
          end
        end
      end
    end
  endtask

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_send || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one element: called at a falling edge, returns at a falling edge.
  task automatic send_element(input logic signed [31:0] v);
    int gap;
    start = 1'b1;
    in_element_value = v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_element(v);
    elements_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      in_element_value = $urandom();
      repeat (gap) @(negedge clk);
    end
  endtask

  // Wait until every expected entry has arrived and the unit has gone quiet.
  task automatic wait_drained();
    start = 1'b0;
    while (pending_entries.size() != 0) @(negedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 31'($urandom());
    if (idx == CFG_IDX_MATRIX_SIZE) begin
      size_reg = data[2:0];
    end else begin
      thresh_reg = data;
    end
  endtask

  function automatic logic signed [31:0] pick_element();
    int roll;
    logic signed [31:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      v = $urandom_range(0, 32'h0008_0000);
      if ($urandom_range(0, 1)) v = -v;
    end else if (roll < 80) begin
      v = $urandom();
    end else if (roll < 88) begin
      v = 32'sd0;
    end else if (roll < 94) begin
      v = $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
    end else begin
      v = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
    end
    return v;
  endfunction

  // Pivot by row swap and update saturation on two 2 x 2 matrices.
  task automatic test_pivot_and_saturation();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd2);
    send_element(Q_ONE);
    send_element(32'sh7000_0000);
    send_element(-Q_ONE);
    send_element(32'sh7000_0000);
    send_element(32'sd1);
    send_element(FIX_MAX);
    send_element(FIX_MIN);
    send_element(32'sd0);
    wait_drained();
  endtask

  // A size of zero acts as one.
  task automatic test_size_zero();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd0);
    send_element(FIX_MIN);
    wait_drained();
  endtask

  // Zero pivots pass with a zero threshold; a high threshold flags singular.
  task automatic test_threshold_extremes();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd2);
    write_reg(CFG_IDX_THRESHOLD, 31'd0);
    repeat (4) send_element(32'sd0);
    wait_drained();
    write_reg(CFG_IDX_THRESHOLD, 31'h7FFF_FFFF);
    send_element(32'sh0000_1234);
    send_element(FIX_MAX);
    send_element(-32'sd5);
    send_element(Q_ONE);
    wait_drained();
    write_reg(CFG_IDX_THRESHOLD, 31'd1);
  endtask

  // Shrinking the size mid-load restarts loading only when the count is past it.
  task automatic test_resize_mid_load();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd2);
    repeat (3) send_element(pick_element());
    wait_drained();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd1);
    send_element(32'sh0003_0000);
    wait_drained();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd2);
    send_element(32'sh0002_0000);
    wait_drained();
    write_reg(CFG_IDX_MATRIX_SIZE, 31'd3);
    repeat (8) send_element(pick_element());
    wait_drained();
  endtask

  // Random phases: random settings, mostly whole matrices, some cut short.
  task automatic test_random_matrices();
    int n, mats, roll, i;
    logic [30:0] th;
    while (elements_sent < 440) begin
      wait_drained();
      steady_send = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        write_reg(CFG_IDX_MATRIX_SIZE, 31'($urandom_range(1, 4)));
      end else begin
        write_reg(CFG_IDX_MATRIX_SIZE,
                  31'($urandom_range(0, 1) ? 0 : $urandom_range(5, 7)));
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
        th = 31'd1;
      end else if (roll < 7) begin
        th = 31'($urandom_range(0, 32'h0002_0000));
      end else if (roll < 8) begin
        th = 31'd0;
      end else if (roll < 9) begin
        th = 31'h7FFF_FFFF;
      end else begin
        th = 31'($urandom());
      end
      write_reg(CFG_IDX_THRESHOLD, th);
      n = (size_reg == 0) ? 1 : ((size_reg > 4) ? 4 : int'(size_reg));
      mats = $urandom_range(1, 4);
      repeat (mats) begin
        for (i = 0; i < n * n; i++) send_element(pick_element());
      end
      // Now and then leave a matrix half loaded across a resize.
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6)) send_element(pick_element());
      end
    end
    steady_send = 1'b0;
  endtask

  // Compare each result transaction with the oldest expected entry.
  always @(posedge clk) begin
    lu_entry_t e;
    if (rst_n && out_valid) begin
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: lu=%h row=%0d col=%0d src=%0d sing=%0b last=%0b",
                   out_lu_value, out_row_index, out_col_index, out_source_row,
                   out_singular, out_last);
      end else begin
        e = pending_entries.pop_front();
        if (out_lu_value !== e.lu_value || out_row_index !== e.row_index ||
            out_col_index !== e.col_index || out_source_row !== e.source_row ||
            out_singular !== e.singular || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected lu=%h row=%0d col=%0d src=%0d sing=%0b ",
                      "last=%0b, got lu=%h row=%0d col=%0d src=%0d sing=%0b last=%0b"},
                     e.lu_value, e.row_index, e.col_index, e.source_row,
                     e.singular, e.last, out_lu_value, out_row_index,
                     out_col_index, out_source_row, out_singular, out_last);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    in_element_value = 32'sd0;
    cfg_we = 1'b0;
    cfg_index = CFG_IDX_MATRIX_SIZE;
    cfg_wdata = 31'd0;
    mismatches = 0;
    cycle_count = 0;
    elements_sent = 0;
    steady_send = 1'b0;
    size_reg = 3'd4;
    thresh_reg = 31'd1;
    load_pos = 0;
    for (i = 0; i < 16; i++) mat[i] = 32'sd0;
    for (i = 0; i < 4; i++) row_src[i] = i[1:0];
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_pivot_and_saturation();
    test_size_zero();
    test_threshold_extremes();
    test_resize_mid_load();
    test_random_matrices();

    wait_drained();
    repeat (600) @(negedge clk);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ lup_decomposition_unit.f @@
+incdir+rtl
rtl/lup_pkg.sv
rtl/lup_div.sv
rtl/lup_dp.sv
rtl/lup_ctrl.sv
rtl/lup_decomposition_unit.sv
verif/lup_decomposition_unit_tb.sv
